[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/slt_pkg.sv]
// ----------------------------------------------------------------------------
// slt_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted list table.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 9;
    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd3;
    localparam logic [OP_W-1:0] OP_COUNT    = 3'd4;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

    // what a newly accepted beat needs from the datapath
    typedef enum logic [1:0] {
        K_NONE,
        K_INS,
        K_DEL
    } t_kind;

    // memory write selection
    typedef enum logic [2:0] {
        WR_NONE,
        WR_UP_DATA,
        WR_UP_VAL,
        WR_ZERO_VAL,
        WR_DOWN_DATA
    } t_wr_sel;

    // index register update
    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef struct packed {
        logic    load;
        t_idx_op idx_op;
        t_wr_sel wr_sel;
        logic    cap_removed;
        logic    finish;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  empty;
        logic  gt;
        logic  idx_zero;
        logic  idx_last;
        logic  out_free;
    } t_sts;

endpackage

[rtl/slt_ctrl.sv]
// ----------------------------------------------------------------------------
// slt_ctrl
// Sequencer for the sorted list table: walks the entry memory one slot
// at a time for inserts and deletes, with a read state for each slot.
// ----------------------------------------------------------------------------
module slt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  slt_pkg::t_sts i_sts,
    output slt_pkg::t_cmd o_cmd
);
    import slt_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_RD   = 4'd1;
    localparam logic [3:0] S_INS_CMP  = 4'd2;
    localparam logic [3:0] S_INS_ZERO = 4'd3;
    localparam logic [3:0] S_DEL_RD   = 4'd4;
    localparam logic [3:0] S_DEL_CAP  = 4'd5;
    localparam logic [3:0] S_DEL_SRD  = 4'd6;
    localparam logic [3:0] S_DEL_SWR  = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state           = r_state;
        o_cmd.load        = 1'b0;
        o_cmd.idx_op      = IDX_HOLD;
        o_cmd.wr_sel      = WR_NONE;
        o_cmd.cap_removed = 1'b0;
        o_cmd.finish      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_sts.kind)
                        K_INS:   n_state = i_sts.empty ? S_INS_ZERO : S_INS_RD;
                        K_DEL:   n_state = S_DEL_RD;
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_INS_RD: n_state = S_INS_CMP;
            S_INS_CMP: begin
                if (i_sts.gt) begin
                    // slide the larger entry up one slot
                    o_cmd.wr_sel = WR_UP_DATA;
                    if (i_sts.idx_zero) begin
                        n_state = S_INS_ZERO;
                    end else begin
                        o_cmd.idx_op = IDX_DEC;
                        n_state      = S_INS_RD;
                    end
                end else begin
                    o_cmd.wr_sel = WR_UP_VAL;
                    n_state      = S_FIN;
                end
            end
            S_INS_ZERO: begin
                o_cmd.wr_sel = WR_ZERO_VAL;
                n_state      = S_FIN;
            end
            S_DEL_RD: n_state = S_DEL_CAP;
            S_DEL_CAP: begin
                o_cmd.cap_removed = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_DEL_SRD;
                end
            end
            S_DEL_SRD: n_state = S_DEL_SWR;
            S_DEL_SWR: begin
                // close the gap: move entry down one slot
                o_cmd.wr_sel = WR_DOWN_DATA;
                if (i_sts.idx_last) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.idx_op = IDX_INC;
                    n_state      = S_DEL_SRD;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/slt_dpath.sv]
// ----------------------------------------------------------------------------
// slt_dpath
// Entry memory, count, slot index, operand and result registers of the
// sorted list table.
// ----------------------------------------------------------------------------
module slt_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  slt_pkg::t_cmd                      i_cmd,
    output slt_pkg::t_sts                      o_sts,
    input  logic [slt_pkg::OP_W-1:0]           i_op,
    input  logic signed [slt_pkg::VAL_W-1:0]   i_value,
    input  logic [slt_pkg::CNT_W-1:0]          i_position,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [slt_pkg::ST_W-1:0]           o_status,
    output logic [slt_pkg::CNT_W-1:0]          o_count,
    output logic signed [slt_pkg::VAL_W-1:0]   o_removed
);
    import slt_pkg::*;

    logic signed [VAL_W-1:0] mem [CAPACITY];
    logic signed [VAL_W-1:0] r_rd_data;

    logic [CNT_W-1:0]        r_count;
    logic [ADDR_W-1:0]       r_idx;
    logic signed [VAL_W-1:0] r_val;
    logic [OP_W-1:0]         r_op;
    logic [ST_W-1:0]         r_status;
    logic signed [VAL_W-1:0] r_removed;

    logic                    r_out_valid;
    logic [ST_W-1:0]         r_out_status;
    logic [CNT_W-1:0]        r_out_count;
    logic signed [VAL_W-1:0] r_out_removed;

    t_kind                   w_kind;
    logic [ST_W-1:0]         w_status;
    logic [ADDR_W-1:0]       w_start;
    logic                    w_empty;
    logic                    w_full;
    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic signed [VAL_W-1:0] w_wdata;
    logic [CNT_W-1:0]        n_count;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_W'(CAPACITY));

    // classify the incoming beat and pick its first slot
    always_comb begin
        w_kind   = K_NONE;
        w_status = ST_OK;
        w_start  = '0;
        case (i_op)
            OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_kind  = K_INS;
                    w_start = r_count[ADDR_W-1:0] - 1'b1;
                end
            end
            OP_DEL_TAIL: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_kind  = K_DEL;
                    w_start = ADDR_W'(r_count - 1'b1);
                end
            end
            OP_DEL_HEAD: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_kind = K_DEL;
                end
            end
            OP_DEL_POS: begin
                if (i_position == '0 || i_position > r_count) begin
                    w_status = ST_INVALID;
                end else begin
                    w_kind  = K_DEL;
                    w_start = ADDR_W'(i_position - 1'b1);
                end
            end
            default: w_status = ST_OK;
        endcase
    end

    // status back to the controller
    assign o_sts.kind     = w_kind;
    assign o_sts.empty    = w_empty;
    assign o_sts.gt       = (r_rd_data > r_val);
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.idx_last = ({1'b0, r_idx} + 1'b1 == r_count);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // memory write port
    always_comb begin
        w_we    = 1'b1;
        w_waddr = r_idx + 1'b1;
        w_wdata = r_rd_data;
        case (i_cmd.wr_sel)
            WR_UP_DATA: begin
                w_waddr = r_idx + 1'b1;
                w_wdata = r_rd_data;
            end
            WR_UP_VAL: begin
                w_waddr = r_idx + 1'b1;
                w_wdata = r_val;
            end
            WR_ZERO_VAL: begin
                w_waddr = '0;
                w_wdata = r_val;
            end
            WR_DOWN_DATA: begin
                w_waddr = r_idx - 1'b1;
                w_wdata = r_rd_data;
            end
            default: w_we = 1'b0;
        endcase
    end

    // entry memory, registered read at the slot index
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[r_idx];
    end

    // count after a finished operation
    always_comb begin
        n_count = r_count;
        if (r_status == ST_OK) begin
            case (r_op)
                OP_INSERT:                          n_count = r_count + 1'b1;
                OP_DEL_TAIL, OP_DEL_HEAD, OP_DEL_POS: n_count = r_count - 1'b1;
                default:                            n_count = r_count;
            endcase
        end
    end

    // operand, index and removed value
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val     <= i_value;
            r_op      <= i_op;
            r_status  <= w_status;
            r_removed <= '0;
        end else if (i_cmd.cap_removed) begin
            r_removed <= r_rd_data;
        end
        if (i_cmd.load) begin
            r_idx <= w_start;
        end else begin
            case (i_cmd.idx_op)
                IDX_INC: r_idx <= r_idx + 1'b1;
                IDX_DEC: r_idx <= r_idx - 1'b1;
                default: r_idx <= r_idx;
            endcase
        end
    end

    // fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_status  <= r_status;
            r_out_count   <= n_count;
            r_out_removed <= r_removed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_count     = r_out_count;
    assign o_removed   = r_out_removed;

endmodule

[rtl/sorted_list_table_top.sv]
// ----------------------------------------------------------------------------
// sorted_list_table_top
// Bounded ascending table of signed 32-bit values with insert, delete
// tail/head/position and count query.
//
//   Channel   Dir  tuser (low bit up)   tdata (low bit up)
//   s_axis    in   operation[2:0]       value[31:0], position[40:32], zero pad
//   m_axis    out  status[1:0]          entry_count[8:0], removed_value[40:9]
//
// One beat in flight at a time. An insert reads each entry larger than its
// value, then one more if a smaller or equal entry exists, else writes its
// value to slot 0; a delete reads its slot and every slot above it.
// The block takes the next beat while a result waits in the result register;
// a second result stalls until it drains. Reset (synchronous, active low)
// empties the table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_list_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // value[31:0], position[40:32], pad
    input  logic [2:0]  s_axis_tuser,   // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // entry_count[8:0], removed_value[40:9], pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import slt_pkg::*;

    t_cmd                    w_cmd;
    t_sts                    w_sts;
    logic [CNT_W-1:0]        w_count;
    logic signed [VAL_W-1:0] w_removed;
    logic                    w_failed;

    slt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    slt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_op        (s_axis_tuser),
        .i_value     (s_axis_tdata[31:0]),
        .i_position  (s_axis_tdata[40:32]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_status    (m_axis_tuser),
        .o_count     (w_count),
        .o_removed   (w_removed)
    );

    assign m_axis_tdata = {7'd0, w_removed, w_count};

    // result on the bus that reports a failed operation
    assign w_failed = m_axis_tvalid && (m_axis_tuser != ST_OK);

    // checks
    `ASSERT_CLK(a_count_bound, !m_axis_tvalid || w_count <= CNT_W'(CAPACITY), "count too big")
    `ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "beat taken while busy")
    `ASSERT_CLK(a_result_then_idle, !$rose(m_axis_tvalid) || s_axis_tready, "result without idle")
    `ASSERT_CLK(a_removed_zero, !w_failed || w_removed == '0, "removed value on failed op")

endmodule

[tb/sorted_list_table_top_tb.sv]
// ----------------------------------------------------------------------------
// sorted_list_table_top_tb
// Self-checking bench for the sorted list table. A mirror of the table,
// kept as a sorted queue, predicts status, count and removed value of each
// operation without a typed expectation. Beats go in through a random-gap
// sender and results come out through a random-stall receiver. The run
// covers a corner-case sweep, a fill to capacity and back, and a long random mix.
// ----------------------------------------------------------------------------
module sorted_list_table_top_tb;
    import slt_pkg::*;

    // codes left unused by the block; they behave as a count query
    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int RANDOM_OPS  = 1220;
    localparam int HOLD_CYCLES = 300;
    // slowest operation walks every slot, plus a hold-off
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 600;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] removed;
    } op_result_t;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] value;
        logic [8:0]       pos;
        bit               typed;
        op_result_t       res;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // value[31:0], position[40:32], pad
    logic [2:0]  s_axis_tuser;   // operation[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // entry_count[8:0], removed_value[40:9], pad
    logic [1:0]  m_axis_tuser;   // status[1:0]

    // mirror of the stored entries, ascending
    logic signed [VAL_W-1:0] sorted_vals[$];
    op_result_t              pending_results[$];
    stim_row_t               dir_rows[$];

    // expectation typed into the directed table for the beat on the bus
    bit         row_typed;
    op_result_t row_expect;

    bit gapless;
    bit hold_req;
    int err_count;
    int beats_in;
    int results_out;
    int hold_count;
    int peak_fill;
    int status_seen[4];
    int stall_cycles;

    sorted_list_table_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // apply one operation to the mirror and return its result
    function automatic op_result_t apply_to_table(logic [OP_W-1:0] op,
                                                  logic signed [VAL_W-1:0] val,
                                                  logic [8:0] pos);
        op_result_t r;
        int slot;
        r.status  = ST_OK;
        r.removed = '0;
        case (op)
            OP_INSERT: begin
                if (sorted_vals.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // equal values stay ahead of the new one
                    slot = 0;
                    while (slot < sorted_vals.size() && !(sorted_vals[slot] > val))
                        slot++;
                    sorted_vals.insert(slot, val);
                end
            end
            OP_DEL_TAIL: begin
                if (sorted_vals.size() == 0) r.status = ST_EMPTY;
                else r.removed = sorted_vals.pop_back();
            end
            OP_DEL_HEAD: begin
                if (sorted_vals.size() == 0) r.status = ST_EMPTY;
                else r.removed = sorted_vals.pop_front();
            end
            OP_DEL_POS: begin
                if (pos == 0 || int'(pos) > sorted_vals.size()) begin
                    r.status = ST_INVALID;
                end else begin
                    r.removed = sorted_vals[pos - 1];
                    sorted_vals.delete(pos - 1);
                end
            end
            default: ;
        endcase
        r.count = CNT_W'(sorted_vals.size());
        return r;
    endfunction

    function automatic stim_row_t mk_row(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
                                         logic [8:0] pos, bit typed = 1'b0,
                                         logic [ST_W-1:0] st = ST_OK,
                                         logic [CNT_W-1:0] cnt = '0,
                                         logic [VAL_W-1:0] rem = '0);
        stim_row_t row;
        row.op    = op;
        row.value = val;
        row.pos   = pos;
        row.typed = typed;
        row.res   = '{status: st, count: cnt, removed: rem};
        return row;
    endfunction

    task automatic report_mismatch(string what, logic [VAL_W-1:0] got,
                                   logic [VAL_W-1:0] want);
        if (err_count < 50)
            $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                     results_out, what, got, want);
        err_count++;
    endtask

    // offer one beat; called and returns at a falling edge
    task automatic send_beat(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
                             logic [8:0] pos, bit typed = 1'b0,
                             op_result_t typed_res = '0);
        while (!gapless && $urandom_range(99) < 28) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'd0, pos, val};
        row_typed  = typed;
        row_expect = typed_res;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // sender pause until every result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    // result check, then prediction for a newly accepted beat
    always @(posedge i_clk) begin : scoreboard
        op_result_t want;
        op_result_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status  = m_axis_tuser;
            got.count   = m_axis_tdata[8:0];
            got.removed = m_axis_tdata[40:9];
            status_seen[got.status]++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat, status", VAL_W'(got.status), '0);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", VAL_W'(got.status), VAL_W'(want.status));
                if (got.count != want.count)
                    report_mismatch("entry_count", VAL_W'(got.count), VAL_W'(want.count));
                if (got.removed != want.removed)
                    report_mismatch("removed_value", got.removed, want.removed);
            end
            results_out++;
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            want = apply_to_table(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[40:32]);
            if (row_typed) want = row_expect;
            pending_results.push_back(want);
            if (sorted_vals.size() > peak_fill) peak_fill = sorted_vals.size();
            beats_in++;
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", stall_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_count++;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= gapless || ($urandom_range(99) >= 28);
        end
    end

    // sender and run control
    initial begin : stimulus
        logic [OP_W-1:0]  op;
        logic [VAL_W-1:0] val;
        logic [VAL_W-1:0] base;
        logic [8:0]       pos;
        int n;
        int ins_pct;
        int pick;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        row_typed     = 1'b0;
        row_expect    = '0;
        gapless       = 1'b0;
        hold_req      = 1'b0;
        stall_cycles  = 0;

        // corner sweep: empty table, extremes, duplicates, bad positions
        dir_rows.push_back(mk_row(OP_COUNT,    '0, 9'd0,   1, ST_OK,      0));
        dir_rows.push_back(mk_row(OP_DEL_TAIL, '0, 9'd0,   1, ST_EMPTY,   0));
        dir_rows.push_back(mk_row(OP_DEL_HEAD, '0, 9'd0,   1, ST_EMPTY,   0));
        dir_rows.push_back(mk_row(OP_DEL_POS,  '0, 9'd1,   1, ST_INVALID, 0));
        dir_rows.push_back(mk_row(OP_DEL_POS,  '0, 9'd0,   1, ST_INVALID, 0));
        dir_rows.push_back(mk_row(OP_DEL_POS,  '0, 9'd256, 1, ST_INVALID, 0));
        dir_rows.push_back(mk_row(OP_INSERT, 32'h7FFF_FFFF, 9'd0, 1, ST_OK, 1));
        dir_rows.push_back(mk_row(OP_INSERT, 32'h8000_0000, 9'd0, 1, ST_OK, 2));
        dir_rows.push_back(mk_row(OP_INSERT, 32'h0000_0000, 9'd0, 1, ST_OK, 3));
        dir_rows.push_back(mk_row(OP_INSERT, 32'hFFFF_FFFF, 9'd0, 1, ST_OK, 4));
        dir_rows.push_back(mk_row(OP_INSERT, 32'd5,         9'd0, 1, ST_OK, 5));
        dir_rows.push_back(mk_row(OP_INSERT, 32'd5,         9'd0, 1, ST_OK, 6));
        dir_rows.push_back(mk_row(OP_INSERT, 32'hFFFF_FFFF, 9'd0, 1, ST_OK, 7));
        dir_rows.push_back(mk_row(OP_DEL_POS, '0, 9'd0,   1, ST_INVALID, 7));
        dir_rows.push_back(mk_row(OP_DEL_POS, '0, 9'd8,   1, ST_INVALID, 7));
        dir_rows.push_back(mk_row(OP_SPARE5,  '0, 9'd0,   1, ST_OK,      7));
        dir_rows.push_back(mk_row(OP_SPARE6,  '1, 9'd511, 1, ST_OK,      7));
        dir_rows.push_back(mk_row(OP_SPARE7,  '0, 9'd3,   1, ST_OK,      7));
        dir_rows.push_back(mk_row(OP_DEL_HEAD, '0, 9'd0, 1, ST_OK, 6, 32'h8000_0000));
        dir_rows.push_back(mk_row(OP_DEL_TAIL, '0, 9'd0, 1, ST_OK, 5, 32'h7FFF_FFFF));
        dir_rows.push_back(mk_row(OP_DEL_POS, '0, 9'd2));
        dir_rows.push_back(mk_row(OP_DEL_POS, '0, 9'd4));
        dir_rows.push_back(mk_row(OP_INSERT, 32'h5555_5555, 9'd0));
        dir_rows.push_back(mk_row(OP_INSERT, 32'hAAAA_AAAA, 9'd0));
        dir_rows.push_back(mk_row(OP_COUNT, '0, 9'd0));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i])
            send_beat(dir_rows[i].op, dir_rows[i].value, dir_rows[i].pos,
                      dir_rows[i].typed, dir_rows[i].res);
        wait_drained();

        // fill to capacity with ascending values, each walk is short
        base = 32'h1000_0000;
        while (sorted_vals.size() < CAPACITY) begin
            if (sorted_vals.size() == CAPACITY / 2) hold_req = 1'b1;
            base = base + VAL_W'($urandom_range(1, 4096));
            send_beat(OP_INSERT, base, 9'($urandom_range(511)));
        end
        send_beat(OP_INSERT, 32'h8000_0000, 9'd0, 1,
                  '{status: ST_FULL, count: CNT_W'(CAPACITY), removed: '0});
        send_beat(OP_INSERT, 32'h7FFF_FFFF, 9'd0, 1,
                  '{status: ST_FULL, count: CNT_W'(CAPACITY), removed: '0});
        send_beat(OP_DEL_POS, '0, 9'(CAPACITY));
        send_beat(OP_DEL_POS, '0, 9'(CAPACITY), 1,
                  '{status: ST_INVALID, count: CNT_W'(CAPACITY - 1), removed: '0});
        send_beat(OP_INSERT, 32'h8000_0000, 9'd0);
        send_beat(OP_DEL_POS, '0, 9'd1);
        send_beat(OP_DEL_HEAD, '0, 9'd0);
        send_beat(OP_DEL_POS, '0, 9'(CAPACITY / 2));
        send_beat(OP_COUNT, '0, 9'd0);
        // drain back down from the top, where a delete walks one slot
        while (sorted_vals.size() > 16)
            send_beat(OP_DEL_TAIL, $urandom(), 9'($urandom_range(511)));

        // random mix; insert odds pull the fill toward a few dozen entries
        for (int k = 0; k < RANDOM_OPS; k++) begin
            gapless = (k >= 400 && k < 700);
            if (k == 850) hold_req = 1'b1;
            if (k == 1000) wait_drained();
            n = sorted_vals.size();
            ins_pct = (n < 8) ? 55 : (n > 40) ? 28 : 45;
            pick = $urandom_range(99);
            if (pick < ins_pct)            op = OP_INSERT;
            else if (pick < ins_pct + 13)  op = OP_DEL_TAIL;
            else if (pick < ins_pct + 26)  op = OP_DEL_HEAD;
            else if (pick < ins_pct + 42)  op = OP_DEL_POS;
            else if (pick < 97)            op = OP_COUNT;
            else                           op = OP_W'($urandom_range(5, 7));
            case ($urandom_range(9))
                0: begin
                    case ($urandom_range(3))
                        0: val = 32'h7FFF_FFFF;
                        1: val = 32'h8000_0000;
                        2: val = 32'h0000_0000;
                        default: val = 32'hFFFF_FFFF;
                    endcase
                end
                1, 2, 3: val = VAL_W'($urandom_range(16)) - 32'd8;
                default: val = $urandom();
            endcase
            if (op == OP_DEL_POS) begin
                case ($urandom_range(9))
                    0: pos = 9'd0;
                    1: pos = 9'(n + 1);
                    2: pos = 9'($urandom_range(256));
                    default: pos = (n == 0) ? 9'd0 : 9'($urandom_range(1, n));
                endcase
            end else begin
                pos = 9'($urandom_range(511));
            end
            send_beat(op, val, pos);
        end
        gapless = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("ran %0d operations (%0d directed), %0d results back, peak fill %0d of %0d",
                 beats_in, dir_rows.size(), results_out, peak_fill, CAPACITY);
        $display("statuses seen: ok %0d, empty %0d, invalid %0d, full %0d; %0d long hold-offs",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_INVALID],
                 status_seen[ST_FULL], hold_count);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_ctrl.sv
rtl/slt_dpath.sv
rtl/sorted_list_table_top.sv
tb/sorted_list_table_top_tb.sv
